[src/eight_op_risc_instruction_step_core_defines.svh]
// ----------------------------------------------------------------------------
// eight_op_risc_instruction_step_core_defines
// assertion macros for the checker file of the step core
// ----------------------------------------------------------------------------
`ifndef EIGHT_OP_RISC_INSTRUCTION_STEP_CORE_DEFINES_SVH
`define EIGHT_OP_RISC_INSTRUCTION_STEP_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define EORISC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define EORISC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/eorisc_pkg.sv]
// ----------------------------------------------------------------------------
// eorisc_pkg
// shared widths, codes and control types of the eight-op risc step core
// ----------------------------------------------------------------------------
`default_nettype none

package eorisc_pkg;

  localparam int DATA_W         = 32;
  localparam int PC_W           = 16;
  localparam int ADDR_IN_W      = 16;
  localparam int CNT_W          = 32;
  localparam int REG_COUNT      = 8;
  localparam int REG_AW         = 3;
  localparam int IR_W           = 25;
  localparam int MEM_ADDR_W_DEF = 16;

  // instruction field positions
  localparam int OPC_LSB = 22;
  localparam int RA_LSB  = 19;
  localparam int RB_LSB  = 16;

  // item operation codes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EXEC  = 2'd1,
    OP_RDREG = 2'd2,
    OP_RDMEM = 2'd3
  } op_t;

  // instruction opcodes
  typedef enum logic [2:0] {
    I_ADD  = 3'd0,
    I_NAND = 3'd1,
    I_LW   = 3'd2,
    I_SW   = 3'd3,
    I_BEQ  = 3'd4,
    I_CMOV = 3'd5,
    I_HALT = 3'd6,
    I_NOOP = 3'd7
  } isa_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_HALT  = 2'd1,
    ST_FAULT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_EXE,
    S_WB,
    S_RDR,
    S_RDM
  } state_t;

  // decoded control from the execute unit
  typedef struct packed {
    logic fault;
    logic halt;
    logic rf_we;
    logic mem_rd;
    logic mem_wr;
  } exe_ctl_t;

endpackage

`default_nettype wire

[src/eight_op_risc_instruction_step_core.sv]
// ----------------------------------------------------------------------------
// eight_op_risc_instruction_step_core
// eight-register word-addressed processor stepped one word at a time
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  -----------------------------------------
//   in       in_valid / in_ready  operation, address, data
//   out      out_valid/out_ready  status, pc, executed_count, read_value
//
// an input word sits in a one-entry input register, so the next word is
// taken while the current one runs; results go through an output register
// each word is paced by the single port of the word memory: a load writes,
// reads take a registered read, execute fetches, decodes and runs, and lw
// adds a write-back; a stopped machine answers execute words without a fetch
// rst is synchronous; there is no clearing pass, unwritten memory is undefined
// a full output register holds the sequencer at its finishing step
//
`default_nettype none

module eight_op_risc_instruction_step_core #(
  parameter int MEM_ADDR_W = eorisc_pkg::MEM_ADDR_W_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             operation,
  input  logic [eorisc_pkg::ADDR_IN_W-1:0]       address,
  input  logic signed [eorisc_pkg::DATA_W-1:0]   data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             status,
  output logic [eorisc_pkg::PC_W-1:0]            pc,
  output logic [eorisc_pkg::CNT_W-1:0]           executed_count,
  output logic signed [eorisc_pkg::DATA_W-1:0]   read_value
);
  import eorisc_pkg::*;

  localparam int MEM_WORDS = 1 << MEM_ADDR_W;

  // input register
  logic                  ib_valid;
  op_t                   ib_op;
  logic [ADDR_IN_W-1:0]  ib_addr;
  logic [DATA_W-1:0]     ib_data;

  // architectural state
  state_t                state;
  state_t                state_next;
  status_t               run_status;
  logic [MEM_ADDR_W-1:0] prog_ctr;
  logic [CNT_W-1:0]      cnt;
  logic [IR_W-1:0]       ir;

  // word memory, single port, registered read
  logic [DATA_W-1:0]     mem [MEM_WORDS];
  logic [DATA_W-1:0]     mem_q;
  logic                  mem_re;
  logic                  mem_we;
  logic [MEM_ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0]     mem_wd;

  // register file, two read ports, one write port, valid bits for reset
  logic [DATA_W-1:0]     rf [REG_COUNT];
  logic [REG_COUNT-1:0]  rf_vld;
  logic [DATA_W-1:0]     rf_qa;
  logic [DATA_W-1:0]     rf_qb;
  logic                  rf_rea;
  logic                  rf_reb;
  logic [REG_AW-1:0]     rf_ra;
  logic [REG_AW-1:0]     rf_rb;
  logic                  rf_we;
  logic [REG_AW-1:0]     rf_wa;
  logic [DATA_W-1:0]     rf_wd;

  // execute unit
  exe_ctl_t              ctl;
  logic [REG_AW-1:0]     ex_wa;
  logic [DATA_W-1:0]     ex_wd;
  logic [MEM_ADDR_W-1:0] ex_ea;
  logic [MEM_ADDR_W-1:0] ex_pc_next;

  // sequencing
  logic                  out_free;
  logic                  needs_out;
  logic                  consume;
  logic                  commit;
  logic                  arch_upd;
  logic                  fault_set;
  logic [DATA_W-1:0]     rd_val;
  status_t               status_after;
  logic [MEM_ADDR_W-1:0] pc_after;
  logic [CNT_W-1:0]      cnt_after;

  assign out_free  = !out_valid || out_ready;
  // words that finish in the start cycle need the output register free
  assign needs_out = (ib_op == OP_LOAD) || ((ib_op == OP_EXEC) && (run_status != ST_RUN));
  assign consume   = (state == S_IDLE) && ib_valid && (!needs_out || out_free);
  assign in_ready  = !ib_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ib_valid <= 1'b1;
    end else if (consume) begin
      ib_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_op   <= op_t'(operation);
      ib_addr <= address;
      ib_data <= data;
    end
  end

  eorisc_exec #(
    .ADDR_W (MEM_ADDR_W)
  ) u_exec (
    .ir       (ir),
    .prog_ctr (prog_ctr),
    .va       (rf_qa),
    .vb       (rf_qb),
    .ctl      (ctl),
    .wa       (ex_wa),
    .wd       (ex_wd),
    .ea       (ex_ea),
    .pc_next  (ex_pc_next)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (consume) begin
          case (ib_op)
            OP_LOAD:  state_next = S_IDLE;
            OP_EXEC:  state_next = (run_status == ST_RUN) ? S_DEC : S_IDLE;
            OP_RDREG: state_next = S_RDR;
            OP_RDMEM: state_next = S_RDM;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_DEC: state_next = S_EXE;
      S_EXE: begin
        if (ctl.mem_rd) state_next = S_WB;
        else if (out_free) state_next = S_IDLE;
      end
      S_WB, S_RDR, S_RDM: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = prog_ctr;
    mem_wd    = rf_qb;
    rf_rea    = 1'b0;
    rf_reb    = 1'b0;
    rf_ra     = mem_q[RA_LSB +: REG_AW];
    rf_rb     = mem_q[RB_LSB +: REG_AW];
    rf_we     = 1'b0;
    rf_wa     = ex_wa;
    rf_wd     = ex_wd;
    commit    = 1'b0;
    arch_upd  = 1'b0;
    fault_set = 1'b0;
    rd_val    = '0;
    case (state)
      S_IDLE: begin
        if (consume) begin
          case (ib_op)
            OP_LOAD: begin
              mem_we   = 1'b1;
              mem_addr = ib_addr[MEM_ADDR_W-1:0];
              mem_wd   = ib_data;
              commit   = 1'b1;
            end
            OP_EXEC: begin
              // instruction fetch, or report a stopped machine as is
              if (run_status == ST_RUN) mem_re = 1'b1;
              else commit = 1'b1;
            end
            OP_RDREG: begin
              rf_rea = 1'b1;
              rf_ra  = ib_addr[REG_AW-1:0];
            end
            OP_RDMEM: begin
              mem_re   = 1'b1;
              mem_addr = ib_addr[MEM_ADDR_W-1:0];
            end
            default: begin
            end
          endcase
        end
      end
      S_DEC: begin
        rf_rea = 1'b1;
        rf_reb = 1'b1;
      end
      S_EXE: begin
        mem_addr = ex_ea;
        if (ctl.mem_rd) begin
          mem_re = 1'b1;
        end else if (out_free) begin
          commit    = 1'b1;
          fault_set = ctl.fault;
          arch_upd  = !ctl.fault;
          rf_we     = ctl.rf_we;
          mem_we    = ctl.mem_wr;
        end
      end
      S_WB: begin
        rf_wd = mem_q;
        if (out_free) begin
          commit   = 1'b1;
          arch_upd = 1'b1;
          rf_we    = 1'b1;
        end
      end
      S_RDR: begin
        rd_val = rf_qa;
        commit = out_free;
      end
      S_RDM: begin
        rd_val = mem_q;
        commit = out_free;
      end
      default: begin
      end
    endcase
  end

  // machine state after the finishing word
  always_comb begin
    status_after = run_status;
    if (fault_set) status_after = ST_FAULT;
    else if (arch_upd && ctl.halt) status_after = ST_HALT;
  end
  assign pc_after  = arch_upd ? ex_pc_next : prog_ctr;
  assign cnt_after = (arch_upd && !(&cnt)) ? cnt + CNT_W'(1) : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_status <= ST_RUN;
      prog_ctr   <= '0;
      cnt        <= '0;
    end else if (commit) begin
      run_status <= status_after;
      prog_ctr   <= pc_after;
      cnt        <= cnt_after;
    end
  end

  // instruction register, taken from the fetch data
  always_ff @(posedge clk) begin
    if (state == S_DEC) begin
      ir <= mem_q[IR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (rf_we) begin
      rf_vld[rf_wa] <= 1'b1;
    end
  end

  // a never written register reads as zero
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (rf_rea) begin
      rf_qa <= rf_vld[rf_ra] ? rf[rf_ra] : '0;
    end
    if (rf_reb) begin
      rf_qb <= rf_vld[rf_rb] ? rf[rf_rb] : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status         <= status_after;
      pc             <= PC_W'(pc_after);
      executed_count <= cnt_after;
      read_value     <= rd_val;
    end
  end

endmodule

`default_nettype wire

[src/eorisc_exec.sv]
// ----------------------------------------------------------------------------
// eorisc_exec
// instruction decode and execute: alu, effective address, next pc
// ----------------------------------------------------------------------------
`default_nettype none

module eorisc_exec #(
  parameter int ADDR_W = eorisc_pkg::MEM_ADDR_W_DEF
) (
  input  logic [eorisc_pkg::IR_W-1:0]   ir,
  input  logic [ADDR_W-1:0]             prog_ctr,
  input  logic [eorisc_pkg::DATA_W-1:0] va,
  input  logic [eorisc_pkg::DATA_W-1:0] vb,
  output eorisc_pkg::exe_ctl_t          ctl,
  output logic [eorisc_pkg::REG_AW-1:0] wa,
  output logic [eorisc_pkg::DATA_W-1:0] wd,
  output logic [ADDR_W-1:0]             ea,
  output logic [ADDR_W-1:0]             pc_next
);
  import eorisc_pkg::*;

  isa_t              opc;
  logic [REG_AW-1:0] rb;
  logic [REG_AW-1:0] rd;
  logic [ADDR_W-1:0] pc_inc;
  logic [ADDR_W-1:0] br_tgt;

  // offset low bits suffice: addresses wrap at the memory depth
  assign opc    = isa_t'(ir[OPC_LSB +: 3]);
  assign rb     = ir[RB_LSB +: REG_AW];
  assign rd     = ir[REG_AW-1:0];
  assign pc_inc = prog_ctr + ADDR_W'(1);
  assign br_tgt = pc_inc + ir[ADDR_W-1:0];
  assign ea     = va[ADDR_W-1:0] + ir[ADDR_W-1:0];

  always_comb begin
    ctl     = '0;
    wa      = rd;
    wd      = va + vb;
    pc_next = pc_inc;
    case (opc)
      I_ADD: begin
        if (rd == '0) ctl.fault = 1'b1;
        else ctl.rf_we = 1'b1;
      end
      I_NAND: begin
        wd = ~(va & vb);
        if (rd == '0) ctl.fault = 1'b1;
        else ctl.rf_we = 1'b1;
      end
      I_LW: begin
        wa = rb;
        if (rb == '0) ctl.fault = 1'b1;
        else ctl.mem_rd = 1'b1;
      end
      I_SW: begin
        ctl.mem_wr = 1'b1;
      end
      I_BEQ: begin
        if (va == vb) pc_next = br_tgt;
      end
      I_CMOV: begin
        wd = va;
        if (rd == '0) ctl.fault = 1'b1;
        else ctl.rf_we = (vb != '0);
      end
      I_HALT: begin
        ctl.halt = 1'b1;
      end
      I_NOOP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[src/eorisc_chk.sv]
// ----------------------------------------------------------------------------
// eorisc_chk
// port-level checks of the step core's result stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "eight_op_risc_instruction_step_core_defines.svh"

module eorisc_chk (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic [1:0]                           status,
  input wire logic [eorisc_pkg::PC_W-1:0]          pc,
  input wire logic [eorisc_pkg::CNT_W-1:0]         executed_count,
  input wire logic signed [eorisc_pkg::DATA_W-1:0] read_value
);
  import eorisc_pkg::*;

  logic             have_last;
  logic [1:0]       last_status;
  logic [PC_W-1:0]  last_pc;
  logic [CNT_W-1:0] last_cnt;

  // last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      have_last   <= 1'b0;
      last_status <= ST_RUN;
      last_pc     <= '0;
      last_cnt    <= '0;
    end else if (out_valid && out_ready) begin
      have_last   <= 1'b1;
      last_status <= status;
      last_pc     <= pc;
      last_cnt    <= executed_count;
    end
  end

  `EORISC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(pc) && $stable(executed_count) && $stable(read_value), "result changed while stalled")
  `EORISC_ASSERT_IMP(a_stop_sticky, out_valid && have_last && (last_status != ST_RUN), status == last_status, "stopped machine restarted")
  `EORISC_ASSERT_IMP(a_cnt_mono, out_valid && have_last, executed_count >= last_cnt, "executed count went backward")
  `EORISC_ASSERT_IMP(a_fault_frozen, out_valid && have_last && (last_status == ST_RUN) && (status == ST_FAULT), (pc == last_pc) && (executed_count == last_cnt), "fault moved pc or count")

endmodule

bind eight_op_risc_instruction_step_core eorisc_chk u_eorisc_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .pc             (pc),
  .executed_count (executed_count),
  .read_value     (read_value)
);

`default_nettype wire
